// ===== hdl/mbc1_pkg.sv =====
`timescale 1ns / 1ps

package mbc1_pkg;

   localparam int RAM_BANKS         = 4;
   localparam int RAM_BANK_BYTES    = 8192;
   localparam int ROM_BANK_BYTES    = 16384;
   localparam int MAX_ROM_BANK_BITS = 7;

   localparam int RAM_DEPTH     = RAM_BANKS * RAM_BANK_BYTES;
   localparam int RAM_ADDR_W    = $clog2(RAM_DEPTH);
   localparam int RAM_OFFSET_W  = $clog2(RAM_BANK_BYTES);
   localparam int ROM_OFFSET_W  = $clog2(ROM_BANK_BYTES);
   localparam int ROM_BANK_W    = MAX_ROM_BANK_BITS;
   localparam int ROM_ADDR_W    = 21;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BANK_BITS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BANK_COUNT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] ROM_BANK_BITS_RESET  = 3'd7;
   localparam logic [CSR_DATA_W-1:0] RAM_BANK_COUNT_RESET = 3'd4;

   localparam logic       OP_READ  = 1'b0;
   localparam logic       OP_WRITE = 1'b1;
   localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   // Register regions by address bits [15:13]; RAM window is 0xA000-0xBFFF.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'b000;
   localparam logic [2:0] REGION_BANK_LOW   = 3'b001;
   localparam logic [2:0] REGION_BANK_HIGH  = 3'b010;
   localparam logic [2:0] REGION_MODE       = 3'b011;
   localparam logic [2:0] REGION_EXT_RAM    = 3'b101;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ROM,
      KIND_RAM_READ,
      KIND_RAM_WRITE
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [RAM_ADDR_W-1:0]   ram_index;
      logic [7:0]              write_byte;
      logic [ROM_ADDR_W-1:0]   rom_address;
   } item_type;

endpackage

// ===== hdl/mbc1_ram.sv =====
`timescale 1ns / 1ps

module mbc1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/mbc1_front.sv =====
`timescale 1ns / 1ps

module mbc1_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mbc1_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbc1_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                accept,
   input  logic                                operation,
   input  logic [15:0]                         bus_address,
   input  logic [7:0]                          write_byte,
   output mbc1_pkg::item_type                  item
);
   import mbc1_pkg::*;

   logic [CSR_DATA_W-1:0] rom_bank_bits_ff, rom_bank_bits_in;
   logic [CSR_DATA_W-1:0] ram_bank_count_ff, ram_bank_count_in;
   logic       ram_enabled_ff, ram_enabled_in;
   logic [4:0] bank_low_ff, bank_low_in;
   logic [1:0] bank_high_ff, bank_high_in;
   logic       banking_mode_ff, banking_mode_in;

   logic [2:0]            region;
   logic [2:0]            bits_clamped;
   logic [ROM_BANK_W-1:0] rom_mask;
   logic [ROM_BANK_W-1:0] rom_bank;
   logic [4:0]            low_eff;
   logic [2:0]            banks_present;
   logic [1:0]            ram_bank_raw;
   logic [1:0]            ram_bank;
   logic                  ram_ok;
   logic [RAM_OFFSET_W+1:0] ram_full_index;

   assign region = bus_address[15:13];

   always_comb begin
      rom_bank_bits_in  = rom_bank_bits_ff;
      ram_bank_count_in = ram_bank_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROM_BANK_BITS:  rom_bank_bits_in  = csr_wdata;
            CSR_RAM_BANK_COUNT: ram_bank_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      ram_enabled_in  = ram_enabled_ff;
      bank_low_in     = bank_low_ff;
      bank_high_in    = bank_high_ff;
      banking_mode_in = banking_mode_ff;
      if (accept && operation == OP_WRITE) begin
         case (region)
            REGION_RAM_ENABLE: ram_enabled_in  = (write_byte[3:0] == RAM_ENABLE_KEY);
            REGION_BANK_LOW:   bank_low_in     = write_byte[4:0];
            REGION_BANK_HIGH:  bank_high_in    = write_byte[1:0];
            REGION_MODE:       banking_mode_in = write_byte[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_bits_ff  <= ROM_BANK_BITS_RESET;
         ram_bank_count_ff <= RAM_BANK_COUNT_RESET;
         ram_enabled_ff    <= 1'b0;
         bank_low_ff       <= '0;
         bank_high_ff      <= '0;
         banking_mode_ff   <= 1'b0;
      end else begin
         rom_bank_bits_ff  <= rom_bank_bits_in;
         ram_bank_count_ff <= ram_bank_count_in;
         ram_enabled_ff    <= ram_enabled_in;
         bank_low_ff       <= bank_low_in;
         bank_high_ff      <= bank_high_in;
         banking_mode_ff   <= banking_mode_in;
      end
   end

   // ROM bank: a bits setting of zero behaves as one, anything above the maximum is clamped.
   always_comb begin
      if (rom_bank_bits_ff == 3'd0) begin
         bits_clamped = 3'd1;
      end else if (32'(rom_bank_bits_ff) > MAX_ROM_BANK_BITS) begin
         bits_clamped = 3'(MAX_ROM_BANK_BITS);
      end else begin
         bits_clamped = rom_bank_bits_ff;
      end
      rom_mask = ROM_BANK_W'((8'd1 << bits_clamped) - 8'd1);
      low_eff  = (bank_low_ff == 5'd0) ? 5'd1 : bank_low_ff;
      if (!bus_address[14]) begin
         rom_bank = banking_mode_ff ? ROM_BANK_W'({bank_high_ff, 5'd0}) : '0;
      end else begin
         rom_bank = ROM_BANK_W'({bank_high_ff, low_eff});
      end
      rom_bank = rom_bank & rom_mask;
   end

   // RAM bank wraps modulo the number of banks present, clamped to what is fitted.
   always_comb begin
      if (32'(ram_bank_count_ff) > RAM_BANKS) begin
         banks_present = 3'(RAM_BANKS);
      end else begin
         banks_present = ram_bank_count_ff;
      end
      ram_ok       = ram_enabled_ff && (banks_present != 3'd0);
      ram_bank_raw = banking_mode_ff ? bank_high_ff : 2'd0;
      case (banks_present)
         3'd1:    ram_bank = 2'd0;
         3'd2:    ram_bank = {1'b0, ram_bank_raw[0]};
         3'd3:    ram_bank = (ram_bank_raw == 2'd3) ? 2'd0 : ram_bank_raw;
         default: ram_bank = ram_bank_raw;
      endcase
      ram_full_index = {ram_bank, bus_address[RAM_OFFSET_W-1:0]};
   end

   always_comb begin
      item.kind        = KIND_NONE;
      item.ram_index   = ram_full_index[RAM_ADDR_W-1:0];
      item.write_byte  = write_byte;
      item.rom_address = '0;
      if (operation == OP_READ) begin
         if (!bus_address[15]) begin
            item.kind        = KIND_ROM;
            item.rom_address = ROM_ADDR_W'({rom_bank, bus_address[ROM_OFFSET_W-1:0]});
         end else if (region == REGION_EXT_RAM && ram_ok) begin
            item.kind = KIND_RAM_READ;
         end
      end else if (region == REGION_EXT_RAM && ram_ok) begin
         item.kind = KIND_RAM_WRITE;
      end
   end

endmodule

// ===== hdl/mbc1_queue.sv =====
`timescale 1ns / 1ps

module mbc1_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbc1_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output mbc1_pkg::item_type pop_item
);
   import mbc1_pkg::*;

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] ptr);
      if (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign full     = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue pushed while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a pushed word");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

// ===== hdl/mbc1_back.sv =====
`timescale 1ns / 1ps

module mbc1_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  mbc1_pkg::item_type               queue_item,
   output logic                             queue_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       read_data,
   output logic                             rom_access,
   output logic [mbc1_pkg::ROM_ADDR_W-1:0]  rom_address
);
   import mbc1_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  from_ram_ff;
   logic                  rom_access_ff;
   logic [ROM_ADDR_W-1:0] rom_address_ff;
   logic                  ram_we;
   logic                  ram_re;
   logic [7:0]            ram_q;

   // The output register frees up in the same cycle its word is taken.
   assign queue_pop = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign ram_we    = queue_pop && (queue_item.kind == KIND_RAM_WRITE);
   assign ram_re    = queue_pop && (queue_item.kind == KIND_RAM_READ);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (queue_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         from_ram_ff    <= (queue_item.kind == KIND_RAM_READ);
         rom_access_ff  <= (queue_item.kind == KIND_ROM);
         rom_address_ff <= queue_item.rom_address;
      end
   end

   mbc1_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (queue_item.ram_index),
      .wdata (queue_item.write_byte),
      .re    (ram_re),
      .raddr (queue_item.ram_index),
      .rdata (ram_q)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign read_data   = from_ram_ff ? ram_q : UNMAPPED_BYTE;
   assign rom_access  = rom_access_ff;
   assign rom_address = rom_address_ff;

endmodule

// ===== hdl/mbc1_bank_mapper.sv =====
`timescale 1ns / 1ps
// An accepted word is written into the queue, then moved into the output register that drives the response side.
// Throughput: one word per cycle, sustained while the response side keeps tready high.
// A four-word queue between the decode stage and the RAM/output stage absorbs stalls.
// Reset clears the bank registers, the mode bit, the queue and the output register, and
// restores the configuration defaults; the external RAM is not cleared and needs no sweep.
module mbc1_bank_mapper (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mbc1_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbc1_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // bus_address[15:0], write_byte[23:16]
   input  logic                             req_tuser,  // operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // read_data[7:0], rom_address[28:8]
   output logic                             rsp_tuser   // rom_access
);
   import mbc1_pkg::*;

   item_type              front_item;
   item_type              queue_item;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  queue_pop;
   logic                  accept;
   logic [7:0]            read_data;
   logic [ROM_ADDR_W-1:0] rom_address;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   mbc1_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .operation   (req_tuser),
      .bus_address (req_tdata[15:0]),
      .write_byte  (req_tdata[23:16]),
      .item        (front_item)
   );

   mbc1_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_item  (queue_item)
   );

   mbc1_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (queue_item),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .read_data   (read_data),
      .rom_access  (rsp_tuser),
      .rom_address (rom_address)
   );

   assign rsp_tdata = {3'b000, rom_address, read_data};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import mbc1_pkg::*;

   // Register indexes that the block decodes to nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int PHASES    = 8;
   localparam int PHASE_LEN = 165;

   typedef struct packed {
      logic [7:0]            read_data;
      logic                  rom_access;
      logic [ROM_ADDR_W-1:0] rom_address;
   } bus_answer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;  // bus_address[15:0], write_byte[23:16]
   logic                   req_tuser = 1'b0;  // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;  // read_data[7:0], rom_address[28:8]
   logic                   rsp_tuser;  // rom_access

   // Mirror of the cartridge state, advanced as each request word is accepted.
   logic [2:0] mirror_rom_bits = ROM_BANK_BITS_RESET;
   logic [2:0] mirror_ram_count = RAM_BANK_COUNT_RESET;
   bit         mirror_ram_on = 1'b0;
   bit [4:0]   mirror_bank_low = '0;
   bit [1:0]   mirror_bank_high = '0;
   bit         mirror_mode = 1'b0;
   bit [7:0]   ram_image [RAM_DEPTH];
   bit         ram_written [RAM_DEPTH];

   bus_answer_type awaited_answers [$];
   int             mismatches = 0;
   bit             steady_traffic = 1'b0;

   mbc1_bank_mapper i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("testbench failed");
      $finish;
   end

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned ram_banks_fitted();
      return (mirror_ram_count > RAM_BANKS) ? RAM_BANKS : mirror_ram_count;
   endfunction

   function automatic bit ram_usable();
      return mirror_ram_on && (ram_banks_fitted() != 0);
   endfunction

   function automatic bit in_ram_window(bit [15:0] addr);
      return addr[15:13] == REGION_EXT_RAM;
   endfunction

   // Only called while at least one RAM bank is present.
   function automatic logic [RAM_ADDR_W-1:0] ram_slot(bit [15:0] addr);
      int unsigned bank;
      int unsigned slot;
      bank = mirror_mode ? mirror_bank_high : 0;
      bank = bank % ram_banks_fitted();
      slot = bank * RAM_BANK_BYTES + addr[12:0];
      return slot[RAM_ADDR_W-1:0];
   endfunction

   function automatic bus_answer_type map_access(bit op, bit [15:0] addr, bit [7:0] data);
      bus_answer_type answer;
      bit [6:0]    bank;
      bit [7:0]    mask;
      int unsigned bits;
      answer.read_data   = UNMAPPED_BYTE;
      answer.rom_access  = 1'b0;
      answer.rom_address = '0;
      if (op == OP_WRITE) begin
         case (addr[15:13])
            REGION_RAM_ENABLE: mirror_ram_on = (data[3:0] == RAM_ENABLE_KEY);
            REGION_BANK_LOW:   mirror_bank_low = data[4:0];
            REGION_BANK_HIGH:  mirror_bank_high = data[1:0];
            REGION_MODE:       mirror_mode = data[0];
            REGION_EXT_RAM: begin
               if (ram_usable()) begin
                  ram_image[ram_slot(addr)] = data;
                  ram_written[ram_slot(addr)] = 1'b1;
               end
            end
            default: ;
         endcase
      end else if (!addr[15]) begin
         if (!addr[14])
            bank = mirror_mode ? {mirror_bank_high, 5'd0} : 7'd0;
         else
            bank = {mirror_bank_high, (mirror_bank_low == 0) ? 5'd1 : mirror_bank_low};
         // A bank width of zero behaves as one bit.
         bits = (mirror_rom_bits == 0) ? 1 : mirror_rom_bits;
         mask = (8'd1 << bits) - 8'd1;
         bank = bank & mask[6:0];
         answer.rom_access  = 1'b1;
         answer.rom_address = {bank, addr[13:0]};
      end else if (in_ram_window(addr) && ram_usable()) begin
         answer.read_data = ram_image[ram_slot(addr)];
      end
      return answer;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < 100)
         $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // A read of a RAM byte that holds nothing yet is turned into a write of it.
   task automatic send_access(bit op, bit [15:0] addr, bit [7:0] data);
      int gap;
      if (op == OP_READ && in_ram_window(addr) && ram_usable()) begin
         if (!ram_written[ram_slot(addr)])
            op = OP_WRITE;
      end
      gap = steady_traffic ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {data, addr};
      do @(posedge clock); while (!req_tready);
      awaited_answers.push_back(map_access(op, addr, data));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_ROM_BANK_BITS)
         mirror_rom_bits = value;
      else if (index == CSR_RAM_BANK_COUNT)
         mirror_ram_count = value;
   endtask

   always @(posedge clock) begin : check_answers
      bus_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("response word arrived with nothing outstanding");
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_tdata[7:0] !== want.read_data)
               report_mismatch($sformatf("read_data %h, wanted %h",
                                         rsp_tdata[7:0], want.read_data));
            if (rsp_tuser !== want.rom_access)
               report_mismatch($sformatf("rom_access %b, wanted %b",
                                         rsp_tuser, want.rom_access));
            if (rsp_tdata[28:8] !== want.rom_address)
               report_mismatch($sformatf("rom_address %h, wanted %h",
                                         rsp_tdata[28:8], want.rom_address));
         end
      end
   end

   // The response side runs stretches of full readiness between bursts of stalls.
   initial begin : rsp_pacing
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(40, 200)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_gap() + 1) @(posedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic test_reset_defaults();
      send_access(OP_READ, 16'h0000, 8'h00);
      send_access(OP_READ, 16'h7FFF, 8'hFF);
      send_access(OP_READ, 16'hA000, 8'h00);
      send_access(OP_READ, 16'h8000, 8'h00);
      send_access(OP_READ, 16'hFFFF, 8'h00);
      send_access(OP_WRITE, 16'h8000, 8'hFF);
      send_access(OP_WRITE, 16'hC000, 8'h00);
   endtask

   task automatic test_ram_enable_window();
      send_access(OP_WRITE, 16'h0000, 8'h0A);
      send_access(OP_WRITE, 16'hA000, 8'h00);
      send_access(OP_WRITE, 16'hBFFF, 8'hFF);
      send_access(OP_READ, 16'hBFFF, 8'h00);
      send_access(OP_READ, 16'hA000, 8'h00);
      // Any low nibble other than the key switches the RAM off.
      send_access(OP_WRITE, 16'h1FFF, 8'hFB);
      send_access(OP_READ, 16'hA000, 8'h00);
      send_access(OP_WRITE, 16'hA000, 8'h55);
      send_access(OP_WRITE, 16'h1FFF, 8'hFA);
      send_access(OP_READ, 16'hA000, 8'h00);
   endtask

   task automatic test_bank_registers();
      send_access(OP_WRITE, 16'h2000, 8'hFF);
      send_access(OP_WRITE, 16'h5FFF, 8'hFF);
      send_access(OP_READ, 16'h4000, 8'h00);
      send_access(OP_WRITE, 16'h7FFF, 8'h01);
      send_access(OP_READ, 16'h3FFF, 8'h00);
      send_access(OP_WRITE, 16'h3FFF, 8'h00);
      send_access(OP_READ, 16'h7FFF, 8'h00);
      send_access(OP_WRITE, 16'h6000, 8'hFE);
      send_access(OP_READ, 16'h0000, 8'h00);
   endtask

   task automatic random_access();
      int         pick;
      bit [1:0]   region;
      bit [12:0]  offset;
      bit [7:0]   data;
      pick = $urandom_range(0, 99);
      data = 8'($urandom_range(0, 255));
      if (pick < 25) begin
         region = 2'($urandom_range(0, 3));
         if (region == REGION_RAM_ENABLE[1:0] && $urandom_range(0, 1))
            data[3:0] = RAM_ENABLE_KEY;
         send_access(OP_WRITE, {1'b0, region, 13'($urandom)}, data);
      end else if (pick < 50) begin
         send_access(OP_READ, {1'b0, 15'($urandom)}, data);
      end else if (pick < 85) begin
         // Mostly a few bytes at either end of a bank, so that reads find written data.
         if ($urandom_range(0, 3) == 0)
            offset = 13'($urandom);
         else
            offset = {$urandom_range(0, 1) ? 9'h1FF : 9'h000, 4'($urandom_range(0, 15))};
         send_access(1'($urandom_range(0, 1)), {REGION_EXT_RAM, offset}, data);
      end else begin
         send_access(1'($urandom_range(0, 1)), 16'($urandom), data);
      end
   endtask

   task automatic bank_switch_burst();
      bit [7:0] key;
      key = {4'($urandom), RAM_ENABLE_KEY};
      send_access(OP_WRITE, {REGION_RAM_ENABLE, 13'($urandom)}, key);
      send_access(OP_WRITE, {REGION_BANK_LOW, 13'($urandom)}, 8'($urandom));
      send_access(OP_WRITE, {REGION_BANK_HIGH, 13'($urandom)}, 8'($urandom));
      send_access(OP_WRITE, {REGION_MODE, 13'($urandom)}, 8'($urandom));
      repeat (4) random_access();
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] rom_bits_plan [PHASES] = '{7, 1, 0, 4, 2, 6, 3, 5};
      logic [CSR_DATA_W-1:0] ram_count_plan [PHASES] = '{4, 0, 1, 2, 3, 5, 7, 6};
      int sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         write_csr(CSR_ROM_BANK_BITS, rom_bits_plan[phase]);
         write_csr(CSR_RAM_BANK_COUNT, ram_count_plan[phase]);
         write_csr(phase[0] ? CSR_SPARE_3 : CSR_SPARE_2, CSR_DATA_W'($urandom_range(0, 7)));
         steady_traffic = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_LEN) begin
            if ($urandom_range(0, 9) == 0) begin
               bank_switch_burst();
               sent += 8;
            end else begin
               random_access();
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_ram_enable_window();
      test_bank_registers();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/mbc1_pkg.sv
hdl/mbc1_ram.sv
hdl/mbc1_front.sv
hdl/mbc1_queue.sv
hdl/mbc1_back.sv
hdl/mbc1_bank_mapper.sv
tb/sv/testbench.sv
